// ----- src/vgnc_pkg.sv -----
// ----------------------------------------------------------------------------
// vgnc_pkg
// Shared constants and types for the voxel grid nearest-centre selector.
// ----------------------------------------------------------------------------
`default_nettype none
package vgnc_pkg;
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic KIND_PASS  = 1'b0;
	localparam logic KIND_REPLY = 1'b1;
	localparam logic [2:0] REG_BASE_X = 3'd0;
	localparam logic [2:0] REG_BASE_Y = 3'd1;
	localparam logic [2:0] REG_BASE_Z = 3'd2;
	localparam logic [2:0] REG_CLEN   = 3'd3;
	localparam logic [2:0] REG_ICLEN  = 3'd4;
	localparam logic [2:0] REG_CX     = 3'd5;
	localparam logic [2:0] REG_CY     = 3'd6;
	localparam logic [2:0] REG_CZ     = 3'd7;

	typedef struct packed {
		logic [31:0] attr;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} point_t;
endpackage
`default_nettype wire

// ----- src/vgnc_ram.sv -----
// ----------------------------------------------------------------------------
// vgnc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module vgnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- src/voxel_grid_nearest_center_select.sv -----
// ----------------------------------------------------------------------------
// voxel_grid_nearest_center_select
// Streams Q16.16 points into a voxel grid, keeping the point nearest each
// cell centre and passing the loser on.
// ----------------------------------------------------------------------------
// Usage: requests enter on s_axis (tuser = action); results leave on m_axis
// (tuser = kind). Configuration registers are written through cfg_we /
// cfg_index / cfg_wdata while the block is idle.
// One request is in flight at a time; it runs through a fixed sequencer:
// index multiply, clamp and linearise, centre, square, sum, then a memory
// read and a read-modify-write. The three axes share one multiplier, one
// centre unit and one squarer, taking the axes in turn in each of those
// steps. An insert into an occupied cell puts the losing point in the
// output register, an insert into an empty cell issues nothing, and the
// next request is accepted in the cycle after the write-back. A read goes
// straight to the memory read and write-back. A clear request sweeps the
// fill memory, one entry a cycle, and the next request is accepted the
// cycle after the sweep ends. After reset the same sweep runs first and
// no request is accepted until it ends.
// The result sits in an output register; a stalled receiver holds it and
// the next request is accepted while it waits, but cannot finish until the
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module voxel_grid_nearest_center_select
	import vgnc_pkg::*;
#(
	parameter int CELL_COUNT     = 4096,
	parameter int AXIS_CELLS_MAX = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// pos_x, pos_y, pos_z, attribute, cell_index, 4 zero bits
	input  wire logic [143:0] s_axis_tdata,
	// action
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_x, out_y, out_z, out_attribute, occupied, 7 zero bits
	output logic      [135:0] m_axis_tdata,
	// kind
	output logic              m_axis_tuser,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata
);
	localparam int AW = $clog2(CELL_COUNT);
	localparam int IW = $clog2(AXIS_CELLS_MAX);
	localparam int CW = $clog2(AXIS_CELLS_MAX + 1);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_IDX  = 4'd3;
	localparam logic [3:0] ST_LIN  = 4'd4;
	localparam logic [3:0] ST_CEN  = 4'd5;
	localparam logic [3:0] ST_SQ   = 4'd6;
	localparam logic [3:0] ST_SUM  = 4'd7;
	localparam logic [3:0] ST_RD   = 4'd8;
	localparam logic [3:0] ST_WB   = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	// configuration
	logic signed [31:0] base_x_q, base_y_q, base_z_q;
	logic [30:0] clen_q, iclen_q;
	logic [4:0]  cx_q, cy_q, cz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0; base_y_q <= '0; base_z_q <= '0;
			clen_q <= 31'd65536; iclen_q <= 31'd65536;
			cx_q <= 5'd16; cy_q <= 5'd16; cz_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_X: base_x_q <= cfg_wdata;
				REG_BASE_Y: base_y_q <= cfg_wdata;
				REG_BASE_Z: base_z_q <= cfg_wdata;
				REG_CLEN:   clen_q <= cfg_wdata[30:0];
				REG_ICLEN:  iclen_q <= cfg_wdata[30:0];
				REG_CX:     cx_q <= cfg_wdata[4:0];
				REG_CY:     cy_q <= cfg_wdata[4:0];
				REG_CZ:     cz_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	function automatic logic [CW-1:0] eff_cells(input logic [4:0] c);
		logic [CW-1:0] r;
		if (c == 5'd0) r = CW'(1);
		else if (32'(c) > AXIS_CELLS_MAX) r = CW'(AXIS_CELLS_MAX);
		else r = CW'(c);
		return r;
	endfunction

	logic [CW-1:0] nx, ny, nz;
	assign nx = eff_cells(cx_q);
	assign ny = eff_cells(cy_q);
	assign nz = eff_cells(cz_q);

	// state and request registers
	logic [3:0]    st_q;
	logic [1:0]    ax_q;
	logic [AW:0]   clr_q;
	point_t        pt_q;
	logic [11:0]   ci_q;
	logic [1:0]    act_q;
	logic signed [32:0] d_q [3];
	logic [31:0]   q_q [3];
	logic [IW-1:0] i_q [3];
	logic [AW-1:0] lin_q;
	logic [31:0]   a_q [3];
	logic          big_q [3];
	logic [63:0]   sq_q [3];
	logic [63:0]   dist_q;

	// output register
	logic         ov_q;
	logic         okind_q, oocc_q;
	point_t       opt_q;

	// memories
	logic          f_we, f_wd, f_rd;
	logic [AW-1:0] f_wa, mem_ra;
	logic          c_we;
	logic [191:0]  c_wd, c_rd;

	vgnc_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_fill (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(mem_ra), .rdata(f_rd)
	);
	vgnc_ram #(.WIDTH(192), .DEPTH(CELL_COUNT)) u_cell (
		.clk(clk), .we(c_we), .waddr(lin_q), .wdata(c_wd), .raddr(mem_ra), .rdata(c_rd)
	);

	logic is_read_ok;
	assign is_read_ok = (32'(ci_q) < CELL_COUNT);
	assign mem_ra = (act_q == ACT_READ) ? AW'(ci_q) : lin_q;

	// per-axis helpers for the current axis
	logic signed [31:0] base_sel;
	logic signed [31:0] pos_sel;
	logic [CW-1:0]      n_sel;
	always_comb begin
		unique case (ax_q)
			2'd0:    begin base_sel = base_x_q; pos_sel = pt_q.x; n_sel = nx; end
			2'd1:    begin base_sel = base_y_q; pos_sel = pt_q.y; n_sel = ny; end
			default: begin base_sel = base_z_q; pos_sel = pt_q.z; n_sel = nz; end
		endcase
	end

	logic [63:0] prod;
	assign prod = 64'(d_q[ax_q][31:0]) * 64'(iclen_q);

	logic signed [65:0] cen, cdiff;
	logic [65:0]        cabs;
	assign cen = 66'(base_sel) + 66'(signed'({1'b0, i_q[ax_q]})) * 66'(signed'({1'b0, clen_q}))
		+ 66'(signed'({1'b0, clen_q[30:1]}));
	assign cdiff = 66'(pos_sel) - cen;
	assign cabs = cdiff[65] ? 66'(-cdiff) : 66'(cdiff);

	logic [64:0] s01, s012;
	logic [63:0] s01s;
	assign s01 = 65'(sq_q[0]) + 65'(sq_q[1]);
	assign s01s = s01[64] ? '1 : s01[63:0];
	assign s012 = 65'(s01s) + 65'(sq_q[2]);

	logic [31:0] lin_w;
	assign lin_w = (32'(i_q[2]) * 32'(ny) + 32'(i_q[1])) * 32'(nx) + 32'(i_q[0]);

	logic out_free;
	assign out_free = !ov_q || m_axis_tready;

	assign s_axis_tready = (st_q == ST_IDLE);

	// memory writes
	always_comb begin
		f_we = 1'b0; f_wa = lin_q; f_wd = 1'b1; c_we = 1'b0;
		c_wd = {dist_q, pt_q};
		if (st_q == ST_CLR) begin
			f_we = 1'b1; f_wa = clr_q[AW-1:0]; f_wd = 1'b0;
		end else if (st_q == ST_WB && act_q == ACT_INSERT && out_free) begin
			if (!f_rd) begin
				f_we = 1'b1; c_we = 1'b1;
			end else if (dist_q < c_rd[191:128]) begin
				c_we = 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; ax_q <= '0; ov_q <= 1'b0;
		end else begin
			// raise the output valid on issue, drop it once taken
			if (st_q == ST_WB && out_free) ov_q <= (act_q == ACT_READ) || f_rd;
			else if (m_axis_tready) ov_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CELL_COUNT - 1) st_q <= ST_IDLE;
				end
				ST_IDLE: if (s_axis_tvalid) begin
					act_q <= s_axis_tuser;
					pt_q <= point_t'(s_axis_tdata[127:0]);
					ci_q <= s_axis_tdata[139:128];
					ax_q <= '0;
					priority case (s_axis_tuser)
						ACT_INSERT: begin
							d_q[0] <= 33'(signed'(s_axis_tdata[31:0])) - 33'(base_x_q);
							d_q[1] <= 33'(signed'(s_axis_tdata[63:32])) - 33'(base_y_q);
							d_q[2] <= 33'(signed'(s_axis_tdata[95:64])) - 33'(base_z_q);
							st_q <= ST_MUL;
						end
						ACT_READ:  st_q <= ST_RD;
						ACT_CLEAR: begin clr_q <= '0; st_q <= ST_CLR; end
						default: ;
					endcase
				end
				// one axis multiply per cycle
				ST_MUL: begin
					q_q[ax_q] <= prod[63:32];
					if (ax_q == 2'd2) begin ax_q <= '0; st_q <= ST_IDX; end
					else ax_q <= ax_q + 1'b1;
				end
				ST_IDX: begin
					for (int k = 0; k < 3; k++) begin
						logic [CW-1:0] nk;
						nk = (k == 0) ? nx : (k == 1) ? ny : nz;
						if (d_q[k][32]) i_q[k] <= '0;
						else if (q_q[k] >= 32'(nk)) i_q[k] <= IW'(nk - 1'b1);
						else i_q[k] <= IW'(q_q[k]);
					end
					st_q <= ST_LIN;
				end
				ST_LIN: begin
					lin_q <= lin_w[AW-1:0];
					st_q <= ST_CEN;
				end
				// centre difference, one axis per cycle
				ST_CEN: begin
					a_q[ax_q] <= cabs[31:0];
					big_q[ax_q] <= |cabs[65:32];
					if (ax_q == 2'd2) begin ax_q <= '0; st_q <= ST_SQ; end
					else ax_q <= ax_q + 1'b1;
				end
				ST_SQ: begin
					sq_q[ax_q] <= big_q[ax_q] ? '1 : 64'(a_q[ax_q]) * 64'(a_q[ax_q]);
					if (ax_q == 2'd2) begin ax_q <= '0; st_q <= ST_SUM; end
					else ax_q <= ax_q + 1'b1;
				end
				ST_SUM: begin
					dist_q <= s012[64] ? '1 : s012[63:0];
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_WB;
				// compare, write back and issue the result
				ST_WB: if (out_free) begin
					st_q <= ST_IDLE;
					if (act_q == ACT_READ) begin
						okind_q <= KIND_REPLY;
						oocc_q <= is_read_ok && f_rd;
						if (is_read_ok && f_rd) opt_q <= point_t'(c_rd[127:0]);
						else opt_q <= '0;
					end else begin
						okind_q <= KIND_PASS;
						oocc_q <= 1'b0;
						if (dist_q < c_rd[191:128]) opt_q <= point_t'(c_rd[127:0]);
						else opt_q <= pt_q;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tdata  = {7'd0, oocc_q, opt_q};
endmodule
`default_nettype wire
